### src/hcta_pkg.sv
// Package: types, constants and lookup functions for the hex-code transliterator.
package hcta_pkg;

   localparam int CharWidth = 8;
   localparam int OutWidth  = 7;
   localparam int CodeWidth = 16;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [OutWidth-1:0]  out_char_type;
   typedef logic [CodeWidth-1:0] code_type;

   // Decoded input item handed from the front end to the lookup stage
   typedef struct packed {
      logic     is_end;
      logic     is_code;
      code_type code;
   } dec_type;

   // Transliterations of 0xC2A0..0xC2BF
   function automatic out_char_type rom_c2(input logic [4:0] idx);
      char_type r;
      case (idx)
         5'd1: r = "i";   5'd2: r = "c";   5'd3: r = "l";   5'd6: r = "|";
         5'd7: r = "S";   5'd9: r = "c";   5'd10: r = "a";  5'd14: r = "r";
         5'd15: r = "-";  5'd16: r = "o";  5'd18: r = "2";  5'd19: r = "3";
         5'd20: r = "'";  5'd21: r = "u";  5'd23: r = ".";  5'd24: r = ".";
         5'd25: r = "1";  5'd26: r = "o";
         5'd0, 5'd13: r = 8'd0;
         default: r = "?";
      endcase
      return r[OutWidth-1:0];
   endfunction

   // 0xC380..0xC39F, upper-case form
   function automatic out_char_type rom_c3_lo_keep(input logic [4:0] idx);
      char_type r;
      case (idx)
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: r = "A";
         5'd7: r = "C";
         5'd8, 5'd9, 5'd10, 5'd11: r = "E";
         5'd12, 5'd13, 5'd14, 5'd15: r = "I";
         5'd16: r = "D";  5'd17: r = "N";
         5'd18, 5'd19, 5'd20, 5'd21, 5'd22: r = "O";
         5'd23: r = "*";  5'd24: r = "0";
         5'd25, 5'd26, 5'd27, 5'd28: r = "U";
         5'd29: r = "Y";  5'd30: r = "p";
         default: r = "B";
      endcase
      return r[OutWidth-1:0];
   endfunction

   // 0xC3A0..0xC3BF, shared by both tables
   function automatic out_char_type rom_c3_hi(input logic [4:0] idx);
      char_type r;
      case (idx)
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: r = "a";
         5'd7: r = "c";
         5'd8, 5'd9, 5'd10, 5'd11: r = "e";
         5'd12, 5'd13, 5'd14, 5'd15: r = "i";
         5'd16: r = "o";  5'd17: r = "n";
         5'd18, 5'd19, 5'd20, 5'd21, 5'd22: r = "o";
         5'd23: r = "/";  5'd24: r = "0";
         5'd25, 5'd26, 5'd27, 5'd28: r = "u";
         5'd29: r = "y";  5'd30: r = "p";
         default: r = "y";
      endcase
      return r[OutWidth-1:0];
   endfunction

   // 0xC380..0xC39F, lower-case form
   function automatic out_char_type rom_c3_lo_fold(input logic [4:0] idx);
      char_type r;
      case (idx)
         5'd16: r = "d";
         5'd23: r = "*";
         5'd24: r = "0";
         5'd29: r = "u";
         5'd30: r = "p";
         5'd31: r = "b";
         default: r = {1'b0, rom_c3_hi(idx)};
      endcase
      return r[OutWidth-1:0];
   endfunction

endpackage

### src/hcta_decoder.sv
// Input register, hex digit decode and nibble assembly.
module hcta_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcta_pkg::char_type req_in_char,
   input  logic              adv,
   output logic              dec_valid,
   output hcta_pkg::dec_type dec
);
   import hcta_pkg::*;

   logic        valid_ff, valid_in;
   char_type    char_ff;
   logic [1:0]  count_ff, count_in;
   logic [11:0] partial_ff, partial_in;
   logic        is_hex;
   logic [3:0]  digit;

   assign req_stall = valid_ff && !adv;
   assign dec_valid = valid_ff;

   // Decode the held character
   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (char_ff inside {["a":"f"]}) begin
         digit = 4'(char_ff - 8'd87);
      end else if (char_ff inside {["A":"F"]}) begin
         digit = 4'(char_ff - 8'd55);
      end else if (char_ff inside {["0":"9"]}) begin
         digit = 4'(char_ff - 8'd48);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign dec.is_end  = !is_hex;
   assign dec.is_code = is_hex && (count_ff == 2'd3);
   assign dec.code    = {partial_ff, digit};

   // Advance the group state when the held transaction moves on
   always_comb begin
      count_in   = count_ff;
      partial_in = partial_ff;
      valid_in   = valid_ff;
      if (valid_ff && adv) begin
         valid_in = 1'b0;
         if (!is_hex || count_ff == 2'd3) begin
            count_in   = 2'd0;
            partial_in = 12'd0;
         end else begin
            count_in   = count_ff + 2'd1;
            partial_in = {partial_ff[7:0], digit};
         end
      end
      if (req_valid && !req_stall) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         count_ff   <= 2'd0;
         partial_ff <= 12'd0;
      end else begin
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         partial_ff <= partial_in;
      end
      if (req_valid && !req_stall) begin
         char_ff <= req_in_char;
      end
   end
endmodule

### src/hcta_lookup.sv
// Code lookup and result register.
module hcta_lookup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  keep_case,
   input  logic                  dec_valid,
   input  hcta_pkg::dec_type     dec,
   output logic                  adv,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hcta_pkg::out_char_type rsp_out_char,
   output logic                  rsp_end_of_text
);
   import hcta_pkg::*;

   logic         valid_ff, valid_in;
   out_char_type char_ff, char_in;
   logic         end_ff;
   logic         hit;
   logic [4:0]   idx;

   assign idx = dec.code[4:0];

   // Look the code up in the table
   always_comb begin
      hit     = 1'b0;
      char_in = 7'd0;
      if (dec.is_end) begin
         hit = 1'b1;
      end else if (dec.is_code) begin
         if (dec.code inside {[16'h0020:16'h007E]}) begin
            hit     = 1'b1;
            char_in = dec.code[6:0];
            if (!keep_case && dec.code inside {[16'h0041:16'h005A]}) begin
               char_in = dec.code[6:0] + 7'd32;
            end
         end else if (dec.code inside {[16'hC2A1:16'hC2BF]} && dec.code != 16'hC2AD) begin
            hit     = 1'b1;
            char_in = rom_c2(idx);
         end else if (dec.code inside {[16'hC3A0:16'hC3BF]}) begin
            hit     = 1'b1;
            char_in = rom_c3_hi(idx);
         end else if (dec.code inside {[16'hC380:16'hC39F]}) begin
            hit     = 1'b1;
            char_in = keep_case ? rom_c3_lo_keep(idx) : rom_c3_lo_fold(idx);
         end
      end
   end

   assign adv      = !valid_ff || !rsp_stall;
   assign valid_in = adv ? (dec_valid && hit) : valid_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_end_of_text = end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         char_ff <= char_in;
         end_ff  <= dec.is_end;
      end
   end
endmodule

### src/hex_code_to_ascii_transliterator_unit.sv
// Path: the input transaction is held in the input register, decoded and looked up, then held in the result register.
// Throughput: one character per cycle while rsp_stall is low; set by the single decode and table lookup stage.
// A completed four-digit group or a non-hex character yields at most one result.
// Reset is synchronous, active high: clears the digit group, keep_case and both valid flags.
// keep_case selects the case-keeping table; it resets to the lower-case table.
module hex_code_to_ascii_transliterator_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hcta_pkg::char_type     req_in_char,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hcta_pkg::out_char_type rsp_out_char,
   output logic                   rsp_end_of_text,
   input  logic                   csr_write,
   input  logic                   csr_keep_case
);
   import hcta_pkg::*;

   logic    keep_case_ff;
   logic    adv;
   logic    dec_valid;
   dec_type dec;

   // Hold the case selection register
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_case_ff <= 1'b0;
      end else if (csr_write) begin
         keep_case_ff <= csr_keep_case;
      end
   end

   hcta_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .adv         (adv),
      .dec_valid   (dec_valid),
      .dec         (dec)
   );

   hcta_lookup u_lookup (
      .clock           (clock),
      .reset           (reset),
      .keep_case       (keep_case_ff),
      .dec_valid       (dec_valid),
      .dec             (dec),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_end_of_text (rsp_end_of_text)
   );
endmodule

### tb/tb_top.sv
// Testbench for the hex-code to ASCII transliterator: queued driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;
   import hcta_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   char_type     req_in_char = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   out_char_type rsp_out_char;
   logic         rsp_end_of_text;
   logic         csr_write = 1'b0;
   logic         csr_keep_case = 1'b0;

   typedef struct packed {
      logic [6:0] ch;
      logic       eot;
   } xlat_result_type;

   char_type        pending_chars[$];
   xlat_result_type expected_chars[$];

   // predictor state
   logic         pred_keep_case = 1'b0;
   logic [1:0]   pred_count = '0;
   logic [11:0]  pred_partial = '0;

   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_cycles = 0;
   int           errors = 0;
   int           quiet_cycles = 0;
   logic         req_taken = 1'b0;

   hex_code_to_ascii_transliterator_unit dut (.*);

   initial forever #5 clock = ~clock;

   // Lower-case folding table, 0xC380..0xC39F
   function automatic logic [6:0] fold_lo(input logic [4:0] i);
      string s;
      byte   b;
      s = "aaaaaaaceeeeiiiidnooooo*0uuuuupb";
      b = s[i];
      return b[6:0];
   endfunction

   function automatic logic [6:0] keep_lo(input logic [4:0] i);
      string s;
      byte   b;
      s = "AAAAAAACEEEEIIIIDNOOOOO*0UUUUYpB";
      b = s[i];
      return b[6:0];
   endfunction

   function automatic logic [6:0] c3_hi(input logic [4:0] i);
      string s;
      byte   b;
      s = "aaaaaaaceeeeiiiionooooo/0uuuuypy";
      b = s[i];
      return b[6:0];
   endfunction

   function automatic logic [6:0] c2_tab(input logic [4:0] i);
      string s;
      byte   b;
      s = "?icl??|S?ca???r-o?23'u?..1o?????";
      b = s[i];
      return b[6:0];
   endfunction

   // Advance the predictor by one accepted character
   task automatic predict_char(input char_type c);
      logic [3:0]      d;
      logic            is_hex;
      logic [15:0]     code;
      xlat_result_type r;
      is_hex = 1'b1;
      d = '0;
      if (c >= "a" && c <= "f") d = 4'(c - 8'd87);
      else if (c >= "A" && c <= "F") d = 4'(c - 8'd55);
      else if (c >= "0" && c <= "9") d = 4'(c - 8'd48);
      else is_hex = 1'b0;
      if (!is_hex) begin
         pred_count = '0;
         pred_partial = '0;
         r.ch = '0;
         r.eot = 1'b1;
         expected_chars.push_back(r);
         return;
      end
      code = {pred_partial, d};
      if (pred_count != 2'd3) begin
         pred_partial = code[11:0];
         pred_count = pred_count + 2'd1;
         return;
      end
      pred_count = '0;
      pred_partial = '0;
      r.eot = 1'b0;
      if (code >= 16'h0020 && code <= 16'h007E) begin
         r.ch = code[6:0];
         if (!pred_keep_case && code >= "A" && code <= "Z") r.ch = code[6:0] + 7'd32;
         expected_chars.push_back(r);
      end else if (code >= 16'hC2A1 && code <= 16'hC2BF && code != 16'hC2AD) begin
         r.ch = c2_tab(code[4:0]);
         expected_chars.push_back(r);
      end else if (code >= 16'hC380 && code <= 16'hC3BF) begin
         if (code >= 16'hC3A0) r.ch = c3_hi(code[4:0]);
         else if (pred_keep_case) r.ch = keep_lo(code[4:0]);
         else r.ch = fold_lo(code[4:0]);
         expected_chars.push_back(r);
      end
   endtask

   function automatic char_type hex_digit(input logic [3:0] v);
      if (v < 10) return char_type'(48 + v);
      if ($urandom_range(0, 1)) return char_type'(87 + v);
      return char_type'(55 + v);
   endfunction

   task automatic queue_code(input logic [15:0] code);
      for (int k = 3; k >= 0; k--) pending_chars.push_back(hex_digit(code[4*k +: 4]));
   endtask

   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 4))
         0: return 16'(32 + $urandom_range(0, 94));
         1: return 16'hC2A0 + 16'($urandom_range(0, 31));
         2: return 16'hC380 + 16'($urandom_range(0, 63));
         3: return 16'($urandom_range(0, 65535));
         default: return 16'h0041 + 16'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic char_type non_hex();
      char_type c;
      do c = char_type'($urandom_range(0, 255));
      while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
      return c;
   endfunction

   // Drive the request channel: hold payload until the transaction is taken; also drive rsp_stall
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (pending_chars.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_in_char <= pending_chars.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Monitor both channels and check results
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_valid && !req_stall) begin
            predict_char(req_in_char);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected result out_char=%0h end_of_text=%0b",
                      rsp_out_char, rsp_end_of_text);
               errors++;
            end else begin
               xlat_result_type e;
               e = expected_chars.pop_front();
               if (rsp_out_char !== e.ch) begin
                  $error("out_char expected %0h actual %0h", e.ch, rsp_out_char);
                  errors++;
               end
               if (rsp_end_of_text !== e.eot) begin
                  $error("end_of_text expected %0b actual %0b", e.eot, rsp_end_of_text);
                  errors++;
               end
            end
         end
         if (quiet_cycles > 5000) begin
            $display("** hex_code_to_ascii_transliterator_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_chars.size() > 0 || req_valid) @(posedge clock);
      while (expected_chars.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_keep_case(input logic v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_keep_case <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      pred_keep_case = v;
   endtask

   task automatic random_phase(input int n);
      int count;
      count = 0;
      while (count < n) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_chars.push_back(non_hex());
            count++;
         end else begin
            queue_code(pick_code());
            count += 4;
         end
      end
      pending_chars.push_back(non_hex());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: case extremes, unmatched codes, partial group ended early
      queue_code(16'h0041);
      queue_code(16'hC39D);
      queue_code(16'hC39E);
      queue_code(16'h0000);
      queue_code(16'hC2AD);
      pending_chars.push_back("f");
      pending_chars.push_back("F");
      pending_chars.push_back(8'hFF);
      pending_chars.push_back(8'h00);
      queue_code(16'hFFFF);
      queue_code(16'h007E);
      drain();
      write_keep_case(1'b1);
      queue_code(16'h0041);
      queue_code(16'hC39D);
      queue_code(16'hC39E);
      queue_code(16'hC3BF);
      pending_chars.push_back("g");
      drain();

      // Random with both idling mixes, then no random idling but a held response stall
      send_idle_pct = 29; recv_idle_pct = 57;
      random_phase(550);
      drain();
      write_keep_case(1'b0);
      send_idle_pct = 57; recv_idle_pct = 29;
      random_phase(550);
      drain();
      write_keep_case(1'b1);
      send_idle_pct = 0; recv_idle_pct = 0;
      hold_cycles = 200;
      random_phase(550);
      drain();

      if (errors == 0 && expected_chars.size() == 0)
         $display("** hex_code_to_ascii_transliterator_unit: PASSED **");
      else
         $display("** hex_code_to_ascii_transliterator_unit: FAILED **");
      $finish;
   end
endmodule
